// ----- hdl/pipt_pkg.sv -----
// shared types and constants for the point-in-polygon test block
// used by the controller, the datapath, the top level and the checker
package pipt_pkg;

  localparam int unsigned MAX_CORNERS = 16;
  localparam int unsigned MIN_CORNERS = 3;
  localparam int unsigned IDX_W       = $clog2(MAX_CORNERS);
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned PROD_W      = 2 * COORD_W;
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4);

  typedef enum logic [0:0] {
    ACT_CORNER = 1'b0,
    ACT_TEST   = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             wr_en;
    logic             start;
    logic             rd_en;
    logic             rd_first;
    logic [IDX_W-1:0] rd_addr;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic             pipe_busy;
    logic             out_free;
    logic [IDX_W-1:0] last_idx;
  } sts_t;

endpackage

// ----- hdl/pipt_ctrl.sv -----
// controller state machine of the point-in-polygon test block
// takes the input handshake, sequences corner reads and result loading; uses pipt_pkg
module pipt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              action_i,
  output logic              in_stall_o,
  input  pipt_pkg::sts_t    sts_i,
  output pipt_pkg::cmd_t    cmd_o
);

  pipt_pkg::state_e                 state_q, state_d;
  logic [pipt_pkg::IDX_W-1:0]       idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pipt_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      pipt_pkg::ST_IDLE: begin
        if (in_valid_i && (action_i == pipt_pkg::ACT_TEST)) begin
          state_d = pipt_pkg::ST_LOAD;
        end
      end
      pipt_pkg::ST_LOAD: begin
        state_d = pipt_pkg::ST_WALK;
        idx_d   = '0;
      end
      pipt_pkg::ST_WALK: begin
        if (idx_q == sts_i.last_idx) begin
          state_d = pipt_pkg::ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      pipt_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = pipt_pkg::ST_DONE;
        end
      end
      pipt_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = pipt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pipt_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      pipt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.wr_en = (action_i == pipt_pkg::ACT_CORNER);
          cmd_o.start = (action_i == pipt_pkg::ACT_TEST);
        end
      end
      pipt_pkg::ST_LOAD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = 1'b1;
        cmd_o.rd_addr  = sts_i.last_idx;
      end
      pipt_pkg::ST_WALK: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = idx_q;
      end
      pipt_pkg::ST_DRAIN: begin
        cmd_o = '0;
      end
      pipt_pkg::ST_DONE: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- hdl/pipt_dp.sv -----
// datapath of the point-in-polygon test block: corner store, edge pipeline,
// crossing flag, count register and result register; uses pipt_pkg
module pipt_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pipt_pkg::cmd_t                      cmd_i,
  output pipt_pkg::sts_t                      sts_o,
  input  logic [pipt_pkg::IDX_W-1:0]          corner_index_i,
  input  logic signed [pipt_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [pipt_pkg::COORD_W-1:0] coord_y_i,
  input  logic                                cfg_valid_i,
  input  logic [pipt_pkg::CNT_W-1:0]          cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                inside_res_o
);

  localparam int unsigned CW = pipt_pkg::COORD_W;
  localparam int unsigned PW = pipt_pkg::PROD_W;
  localparam int unsigned NW = pipt_pkg::CNT_W;

  // difference a - b as sign and magnitude, magnitude always fits CW bits
  function automatic logic [CW:0] sub_sm(input logic signed [CW-1:0] a,
                                         input logic signed [CW-1:0] b);
    logic signed [CW:0] t;
    logic        [CW:0] t_neg;
    t     = {a[CW-1], a} - {b[CW-1], b};
    t_neg = -t;
    if (t[CW]) begin
      return {1'b1, t_neg[CW-1:0]};
    end
    return {1'b0, t[CW-1:0]};
  endfunction

  // strict less-than on sign-magnitude values
  function automatic logic less_sm(input logic an, input logic [PW-1:0] am,
                                   input logic bn, input logic [PW-1:0] bm);
    if (an != bn) begin
      return an;
    end
    if (an) begin
      return am > bm;
    end
    return am < bm;
  endfunction

  logic signed [CW-1:0] mem_x [pipt_pkg::MAX_CORNERS];
  logic signed [CW-1:0] mem_y [pipt_pkg::MAX_CORNERS];

  logic [NW-1:0]        count_q;
  logic [NW-1:0]        n_act;
  logic [NW-1:0]        last_full;

  logic signed [CW-1:0] px_q, py_q;
  logic signed [CW-1:0] rd_x_q, rd_y_q;
  logic                 rd_v_q, rd_first_q;
  logic signed [CW-1:0] prev_x_q, prev_y_q;

  logic [CW:0]          dy_sm, dx_sm, dp_sm, dd_sm;
  logic                 straddle;

  logic                 s1_v_q, s1_cnt_q, s1_dpos_q, s1_ls_q, s1_rs_q;
  logic [CW-1:0]        s1_dy_q, s1_dx_q, s1_dp_q, s1_dd_q;

  logic                 s2_v_q, s2_cnt_q, s2_dpos_q, s2_ls_q, s2_rs_q;
  logic [PW-1:0]        s2_lm_q, s2_rm_q;

  logic                 ln, rn, hit;
  logic                 inside_q;
  logic                 out_valid_q, inside_res_q;

  // corner count register with clamping to the usable range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= pipt_pkg::COUNT_RESET;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (count_q < NW'(pipt_pkg::MIN_CORNERS)) begin
      n_act = NW'(pipt_pkg::MIN_CORNERS);
    end else if (count_q > NW'(pipt_pkg::MAX_CORNERS)) begin
      n_act = NW'(pipt_pkg::MAX_CORNERS);
    end else begin
      n_act = count_q;
    end
    last_full = n_act - NW'(1);
  end

  // corner store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_x[corner_index_i] <= coord_x_i;
      mem_y[corner_index_i] <= coord_y_i;
    end
    if (cmd_i.rd_en) begin
      rd_x_q <= mem_x[cmd_i.rd_addr];
      rd_y_q <= mem_y[cmd_i.rd_addr];
    end
  end

  // test point
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
  end

  // edge from previous corner j to current corner i
  always_comb begin
    dy_sm    = sub_sm(py_q, rd_y_q);
    dx_sm    = sub_sm(prev_x_q, rd_x_q);
    dp_sm    = sub_sm(px_q, rd_x_q);
    dd_sm    = sub_sm(prev_y_q, rd_y_q);
    straddle = ((rd_y_q < py_q) && (prev_y_q >= py_q)) ||
               ((prev_y_q < py_q) && (rd_y_q >= py_q));
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prev_x_q <= rd_x_q;
      prev_y_q <= rd_y_q;
    end
    s1_cnt_q  <= straddle;
    s1_dpos_q <= ~dd_sm[CW];
    s1_ls_q   <= dy_sm[CW] ^ dx_sm[CW];
    s1_rs_q   <= dp_sm[CW] ^ dd_sm[CW];
    s1_dy_q   <= dy_sm[CW-1:0];
    s1_dx_q   <= dx_sm[CW-1:0];
    s1_dp_q   <= dp_sm[CW-1:0];
    s1_dd_q   <= dd_sm[CW-1:0];
    s2_cnt_q  <= s1_cnt_q;
    s2_dpos_q <= s1_dpos_q;
    s2_ls_q   <= s1_ls_q;
    s2_rs_q   <= s1_rs_q;
    s2_lm_q   <= s1_dy_q * s1_dx_q;
    s2_rm_q   <= s1_dp_q * s1_dd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q     <= 1'b0;
      rd_first_q <= 1'b0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
    end else begin
      rd_v_q     <= cmd_i.rd_en;
      rd_first_q <= cmd_i.rd_first;
      s1_v_q     <= rd_v_q & ~rd_first_q;
      s2_v_q     <= s1_v_q;
    end
  end

  // crossing decision
  always_comb begin
    ln  = s2_ls_q & (|s2_lm_q);
    rn  = s2_rs_q & (|s2_rm_q);
    hit = s2_dpos_q ? less_sm(ln, s2_lm_q, rn, s2_rm_q)
                    : less_sm(rn, s2_rm_q, ln, s2_lm_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else if (cmd_i.start) begin
      inside_q <= 1'b0;
    end else if (s2_v_q && s2_cnt_q && hit) begin
      inside_q <= ~inside_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      inside_res_q <= inside_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign inside_res_o    = inside_res_q;
  assign sts_o.pipe_busy = rd_v_q | s1_v_q | s2_v_q;
  assign sts_o.out_free  = ~out_valid_q | ~out_stall_i;
  assign sts_o.last_idx  = last_full[pipt_pkg::IDX_W-1:0];

endmodule

// ----- hdl/point_in_polygon_test_core.sv -----
// top level of the point-in-polygon test block
// joins pipt_ctrl and pipt_dp; uses pipt_pkg
//
// Crossing-number point-in-polygon test on up to 16 fixed-point corners.
// A corner word (action 0) is written to the corner store in the cycle it is
// accepted and gives no result. A test word (action 1) walks all edges of the
// polygon through an edge pipeline (read, s1 and s2 registers) fed by one
// corner-store read per cycle: one read for the closing corner and one per
// corner, then the pipeline drains and the inside flag is loaded into the
// result register once that register is free (empty, or its result is taken
// by an unstalled output); the input is stalled from acceptance until then.
// The result register decouples the output, so a new word is taken while a
// finished result still waits. corner_count is clamped to 3..16 and is to be
// written through the configuration port while idle by the user; the block
// itself does not enforce this.
module point_in_polygon_test_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic [pipt_pkg::IDX_W-1:0]          corner_index_i,
  input  logic signed [pipt_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [pipt_pkg::COORD_W-1:0] coord_y_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pipt_pkg::CNT_W-1:0]          cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                inside_res_o
);

  pipt_pkg::cmd_t cmd;
  pipt_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  pipt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pipt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .corner_index_i (corner_index_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inside_res_o   (inside_res_o)
  );

endmodule

// ----- hdl/pipt_chk.sv -----
// port-level checker for point_in_polygon_test_core and its bind
// uses pipt_pkg for the action codes
module pipt_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic action_i,
  input logic out_valid_o,
  input logic out_stall_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == pipt_pkg::ACT_TEST) |=> in_stall_o)
    else $error("test word did not make the block busy");

  a_corner_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == pipt_pkg::ACT_CORNER) |=> !in_stall_o)
    else $error("corner word stalled the input");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("test finished without a result");

endmodule

bind point_in_polygon_test_core pipt_chk u_pipt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
